>>> design/grtg_pkg.sv
// shared types and constants for the gradient ramp table generator
`default_nettype none

package grtg_pkg;

    localparam int POS_W = 8;
    localparam int COLOR_W = 32;
    localparam int CHAN_W = 8;
    localparam int NUM_CHAN = 4;
    localparam int RAMP_ENTRIES = 256;
    localparam int LANES = 8;
    localparam int ROWS = RAMP_ENTRIES / LANES;
    localparam int ROW_W = $clog2(ROWS);
    localparam int LANE_W = $clog2(LANES);
    localparam int ADDR_W = $clog2(RAMP_ENTRIES);
    localparam int CHUNK_W = ROW_W + 1;
    localparam int DIV_CNT_W = $clog2(CHAN_W);

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_GENERATE = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_REFLECT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SWAP = 2'd1;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    typedef logic [COLOR_W-1:0] color_t;

    typedef enum logic [1:0] {
        CMD_CLEAR,
        CMD_APPEND,
        CMD_GENERATE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic [POS_W-1:0] pos;
        color_t color;
    } cmd_t;

    typedef struct packed {
        logic reflect;
        logic swap;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic [CHAN_W-1:0] divisor;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic done;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;
        logic [NUM_CHAN-1:0][CHAN_W-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LOAD,
        BK_FILL,
        BK_NEXT,
        BK_CHECK,
        BK_DIV,
        BK_SPAN,
        BK_TAIL,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

>>> design/grtg_front.sv
// front end: input handshake and decode of the request into a queued command
`default_nettype none

module grtg_front
    import grtg_pkg::*;
(
    input  wire logic              push,
    output logic                   full,
    input  wire logic [OP_W-1:0]   operation,
    input  wire logic [POS_W-1:0]  stop_pos,
    input  wire color_t            stop_color,
    input  wire logic              q_full,
    output logic                   enq_valid,
    output cmd_t                   enq_cmd
);

    logic known;

    always_comb
    begin
        known = 1'b1;
        enq_cmd.pos = stop_pos;
        enq_cmd.color = stop_color;
        enq_cmd.kind = CMD_CLEAR;
        unique case (operation)
            OP_CLEAR:    enq_cmd.kind = CMD_CLEAR;
            OP_APPEND:   enq_cmd.kind = CMD_APPEND;
            OP_GENERATE: enq_cmd.kind = CMD_GENERATE;
            // unused code is taken and dropped
            default:     known = 1'b0;
        endcase
    end

    assign full = q_full;
    assign enq_valid = push && !q_full && known;

endmodule

`default_nettype wire

>>> design/grtg_queue.sv
// short command queue between the front end and the ramp engine
`default_nettype none

module grtg_queue
    import grtg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic rd_en,
    output logic      valid,
    output cmd_t      rd_cmd
);

    cmd_t entry_mem [CMD_QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic do_wr, do_rd;

    assign full = (cnt_reg == QCNT_W'(CMD_QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign rd_cmd = entry_mem[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/grtg_div.sv
// four-lane restoring divider, one quotient bit per cycle, shared by all spans
`default_nettype none

module grtg_div
    import grtg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [CHAN_W-1:0] divisor_reg, divisor_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] rem_reg, rem_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] quo_reg, quo_next;
    logic [CHAN_W:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        divisor_next = divisor_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial = '0;
        priority if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            divisor_next = req.divisor;
            rem_next = '0;
            quo_next = req.dividend;
        end
        else if (busy_reg)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                trial = {rem_reg[ch], quo_reg[ch][CHAN_W-1]};
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next[ch] = CHAN_W'(trial - {1'b0, divisor_reg});
                    quo_next[ch] = {quo_reg[ch][CHAN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[ch] = trial[CHAN_W-1:0];
                    quo_next[ch] = {quo_reg[ch][CHAN_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(CHAN_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            // idle: hold the last result
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem = rem_reg;

endmodule

`default_nettype wire

>>> design/grtg_back.sv
// ramp engine: stop list, ramp build sequencer, banked ramp memory and chunk output
`default_nettype none

module grtg_back
    import grtg_pkg::*;
#(
    parameter int MAX_STOPS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     q_valid,
    input  wire cmd_t     q_cmd,
    output logic          q_pop,
    output div_req_t      div_req,
    input  wire div_rsp_t div_rsp,
    input  wire logic     pop,
    output logic          out_valid,
    output logic [CHUNK_W-1:0] out_chunk,
    output color_t        out_color [LANES],
    output logic          out_last
);

    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int SIDX_W = $clog2(MAX_STOPS);

    // stop list
    logic [POS_W-1:0] stop_pos_mem [MAX_STOPS];
    color_t stop_col_mem [MAX_STOPS];
    logic stop_we, stop_re;
    logic [SIDX_W-1:0] stop_raddr;
    logic [POS_W-1:0] rd_pos_reg;
    color_t rd_col_reg;

    // ramp memory write and read ports
    logic ramp_we, ramp_re;
    color_t ramp_wdata;
    logic [ROW_W-1:0] ramp_rrow;
    color_t bank_rd [LANES];

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] k_reg, k_next, k_plus1;
    logic [ADDR_W:0] e_reg, e_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic out_valid_reg, out_valid_next;

    logic [ADDR_W:0] i_end_reg, i_end_next;
    logic [POS_W-1:0] a_pos_reg, a_pos_next;
    color_t a_col_reg, a_col_next;
    logic [CHAN_W-1:0] d_reg, d_next;
    logic [NUM_CHAN-1:0] neg_reg, neg_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] q_reg, q_next;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r_reg, r_next;
    logic zero_reg, zero_next;
    logic [CHUNK_W-1:0] out_chunk_reg, out_chunk_next;
    logic out_last_reg, out_last_next;
    logic out_mirror_reg, out_mirror_next;
    logic out_zero_reg, out_zero_next;

    // per-channel span arithmetic
    logic [NUM_CHAN-1:0] neg_w;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] mag_w;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] lerp_w;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] q_step;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] r_step;
    logic [CHAN_W:0] r_sum;
    logic r_wrap;
    color_t span_color;
    logic [CHUNK_W-1:0] last_chunk;
    logic out_free;

    assign k_plus1 = k_reg + CNT_W'(1);
    assign last_chunk = {cfg.reflect, {ROW_W{1'b1}}};
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        r_sum = '0;
        r_wrap = 1'b0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            neg_w[ch] = rd_col_reg[ch*CHAN_W +: CHAN_W] < a_col_reg[ch*CHAN_W +: CHAN_W];
            mag_w[ch] = neg_w[ch]
                ? a_col_reg[ch*CHAN_W +: CHAN_W] - rd_col_reg[ch*CHAN_W +: CHAN_W]
                : rd_col_reg[ch*CHAN_W +: CHAN_W] - a_col_reg[ch*CHAN_W +: CHAN_W];
            lerp_w[ch] = neg_reg[ch]
                ? a_col_reg[ch*CHAN_W +: CHAN_W] - q_reg[ch]
                : a_col_reg[ch*CHAN_W +: CHAN_W] + q_reg[ch];
            // quotient and remainder of |diff|*t/d advance by |diff|/d per entry
            r_sum = {1'b0, r_reg[ch]} + {1'b0, div_rsp.rem[ch]};
            r_wrap = (r_sum >= {1'b0, d_reg});
            r_step[ch] = r_wrap ? CHAN_W'(r_sum - {1'b0, d_reg}) : r_sum[CHAN_W-1:0];
            q_step[ch] = q_reg[ch] + div_rsp.quot[ch] + {{(CHAN_W-1){1'b0}}, r_wrap};
        end
        if (cfg.swap)
        begin
            span_color = {lerp_w[3], lerp_w[0], lerp_w[1], lerp_w[2]};
        end
        else
        begin
            span_color = {lerp_w[3], lerp_w[2], lerp_w[1], lerp_w[0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next = k_reg;
        e_next = e_reg;
        chunk_next = chunk_reg;
        i_end_next = i_end_reg;
        a_pos_next = a_pos_reg;
        a_col_next = a_col_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        q_next = q_reg;
        r_next = r_reg;
        zero_next = zero_reg;
        out_chunk_next = out_chunk_reg;
        out_last_next = out_last_reg;
        out_mirror_next = out_mirror_reg;
        out_zero_next = out_zero_reg;
        out_valid_next = pop ? 1'b0 : out_valid_reg;

        q_pop = 1'b0;
        stop_we = 1'b0;
        stop_re = 1'b0;
        stop_raddr = '0;
        ramp_we = 1'b0;
        ramp_wdata = a_col_reg;
        ramp_re = 1'b0;
        div_req.start = 1'b0;
        div_req.divisor = rd_pos_reg - a_pos_reg;
        div_req.dividend = mag_w;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_APPEND:
                        begin
                            // a stop beyond capacity is dropped
                            if (count_reg < CNT_W'(MAX_STOPS))
                            begin
                                stop_we = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_GENERATE:
                        begin
                            chunk_next = '0;
                            if (count_reg == '0)
                            begin
                                zero_next = 1'b1;
                                state_next = BK_EMIT;
                            end
                            else
                            begin
                                zero_next = 1'b0;
                                stop_re = 1'b1;
                                state_next = BK_LOAD;
                            end
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            BK_LOAD:
            begin
                a_pos_next = rd_pos_reg;
                a_col_next = rd_col_reg;
                e_next = '0;
                state_next = BK_FILL;
            end
            BK_FILL:
            begin
                ramp_we = 1'b1;
                if (e_reg[ADDR_W-1:0] == a_pos_reg)
                begin
                    i_end_next = {1'b0, a_pos_reg} + (ADDR_W+1)'(1);
                    k_next = '0;
                    state_next = BK_NEXT;
                end
                else
                begin
                    e_next = e_reg + (ADDR_W+1)'(1);
                end
            end
            BK_NEXT:
            begin
                if (k_plus1 < count_reg)
                begin
                    stop_re = 1'b1;
                    stop_raddr = k_plus1[SIDX_W-1:0];
                    state_next = BK_CHECK;
                end
                else
                begin
                    e_next = i_end_reg;
                    state_next = BK_TAIL;
                end
            end
            BK_CHECK:
            begin
                if (rd_pos_reg > a_pos_reg)
                begin
                    div_req.start = 1'b1;
                    d_next = rd_pos_reg - a_pos_reg;
                    neg_next = neg_w;
                    state_next = BK_DIV;
                end
                else
                begin
                    // falling or equal pair fills nothing
                    a_pos_next = rd_pos_reg;
                    a_col_next = rd_col_reg;
                    k_next = k_plus1;
                    state_next = BK_NEXT;
                end
            end
            BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next = '0;
                    r_next = '0;
                    e_next = {1'b0, a_pos_reg};
                    state_next = BK_SPAN;
                end
            end
            BK_SPAN:
            begin
                ramp_we = 1'b1;
                ramp_wdata = span_color;
                q_next = q_step;
                r_next = r_step;
                if (e_reg[ADDR_W-1:0] == rd_pos_reg - POS_W'(1))
                begin
                    i_end_next = {1'b0, rd_pos_reg};
                    a_pos_next = rd_pos_reg;
                    a_col_next = rd_col_reg;
                    k_next = k_plus1;
                    state_next = BK_NEXT;
                end
                else
                begin
                    e_next = e_reg + (ADDR_W+1)'(1);
                end
            end
            BK_TAIL:
            begin
                if (e_reg[ADDR_W])
                begin
                    chunk_next = '0;
                    state_next = BK_EMIT;
                end
                else
                begin
                    ramp_we = 1'b1;
                    e_next = e_reg + (ADDR_W+1)'(1);
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    ramp_re = 1'b1;
                    out_valid_next = 1'b1;
                    out_chunk_next = chunk_reg;
                    out_last_next = (chunk_reg == last_chunk);
                    out_mirror_next = chunk_reg[CHUNK_W-1];
                    out_zero_next = zero_reg;
                    chunk_next = chunk_reg + CHUNK_W'(1);
                    if (chunk_reg == last_chunk)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            count_reg <= '0;
            k_reg <= '0;
            e_reg <= '0;
            chunk_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg <= k_next;
            e_reg <= e_next;
            chunk_reg <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_end_reg <= i_end_next;
        a_pos_reg <= a_pos_next;
        a_col_reg <= a_col_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        q_reg <= q_next;
        r_reg <= r_next;
        zero_reg <= zero_next;
        out_chunk_reg <= out_chunk_next;
        out_last_reg <= out_last_next;
        out_mirror_reg <= out_mirror_next;
        out_zero_reg <= out_zero_next;
    end

    always_ff @(posedge clk)
    begin
        if (stop_we)
        begin
            stop_pos_mem[count_reg[SIDX_W-1:0]] <= q_cmd.pos;
            stop_col_mem[count_reg[SIDX_W-1:0]] <= q_cmd.color;
        end
        if (stop_re)
        begin
            rd_pos_reg <= stop_pos_mem[stop_raddr];
            rd_col_reg <= stop_col_mem[stop_raddr];
        end
    end

    // mirrored half reads rows in reverse order, lanes are reversed at the output
    assign ramp_rrow = chunk_reg[CHUNK_W-1] ? ~chunk_reg[ROW_W-1:0] : chunk_reg[ROW_W-1:0];

    for (genvar b = 0; b < LANES; b++)
    begin : g_bank
        color_t bank_mem [ROWS];
        color_t bank_q;

        always_ff @(posedge clk)
        begin
            if (ramp_we && (e_reg[LANE_W-1:0] == LANE_W'(b)))
            begin
                bank_mem[e_reg[ADDR_W-1:LANE_W]] <= ramp_wdata;
            end
            if (ramp_re)
            begin
                bank_q <= bank_mem[ramp_rrow];
            end
        end

        assign bank_rd[b] = bank_q;
    end

    for (genvar j = 0; j < LANES; j++)
    begin : g_lane
        assign out_color[j] = out_zero_reg ? '0
                            : (out_mirror_reg ? bank_rd[LANES-1-j] : bank_rd[j]);
    end

    assign out_valid = out_valid_reg;
    assign out_chunk = out_chunk_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire

>>> design/gradient_ramp_table_generator_unit.sv
// top level of the gradient ramp table generator
//
// Requests come in through a push/full queue port: clear the stop list, append a stop
// (position and ARGB color; stops past MAX_STOPS are dropped) or generate the ramp.
// Clear and append are done by the ramp engine in its idle state. A generate builds
// the 256-entry ramp into eight 32-row memory banks, one entry written per cycle in
// the fill and span states: a leading fill up to the first stop, then for each later
// stop a read and check of the stop list and, for every rising pair, a divide on the
// shared four-lane divider and a span of interpolated entries, then the trailing fill.
// The banks then deliver one chunk of eight entries per cycle (32 chunks, or 64 with
// reflect_mode) while pop keeps up. With an empty stop list the build is skipped and
// zero chunks follow at once. A two-deep command queue lets clears and appends be taken
// while a generate is running, and the ramp engine can start the next command while the
// final chunk still waits to be popped. Configuration registers (index 0 reflect_mode,
// 1 swap_red_blue) must be written only while the block is idle; the block itself does
// not enforce this, and cfg_ready is always high.
`default_nettype none

module gradient_ramp_table_generator_unit
    import grtg_pkg::*;
#(
    parameter int MAX_STOPS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             operation,
    input  wire logic [7:0]             stop_pos,
    input  wire logic [31:0]            stop_color,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [5:0]                  chunk_index,
    output logic [31:0]                 color_0,
    output logic [31:0]                 color_1,
    output logic [31:0]                 color_2,
    output logic [31:0]                 color_3,
    output logic [31:0]                 color_4,
    output logic [31:0]                 color_5,
    output logic [31:0]                 color_6,
    output logic [31:0]                 color_7,
    output logic                        last,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                   cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic q_full, enq_valid, q_valid, q_pop;
    cmd_t enq_cmd, q_cmd;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic out_valid, out_pop;
    color_t out_color [LANES];

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_REFLECT: cfg_next.reflect = cfg_data;
                CFG_SWAP:    cfg_next.swap = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    grtg_front u_front (
        .push       (push),
        .full       (full),
        .operation  (operation),
        .stop_pos   (stop_pos),
        .stop_color (stop_color),
        .q_full     (q_full),
        .enq_valid  (enq_valid),
        .enq_cmd    (enq_cmd)
    );

    grtg_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (enq_valid),
        .wr_cmd (enq_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .valid  (q_valid),
        .rd_cmd (q_cmd)
    );

    grtg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_pop = pop && out_valid;

    grtg_back #(
        .MAX_STOPS (MAX_STOPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .pop       (out_pop),
        .out_valid (out_valid),
        .out_chunk (chunk_index),
        .out_color (out_color),
        .out_last  (last)
    );

    assign empty = !out_valid;
    assign color_0 = out_color[0];
    assign color_1 = out_color[1];
    assign color_2 = out_color[2];
    assign color_3 = out_color[3];
    assign color_4 = out_color[4];
    assign color_5 = out_color[5];
    assign color_6 = out_color[6];
    assign color_7 = out_color[7];

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for gradient_ramp_table_generator_unit with a built-in ramp predictor
`timescale 1ns / 1ps

module tb_top;
    import grtg_pkg::*;

    localparam int MAX_STOPS = 16;
    localparam int DRAIN_CYCLES = 600;
    localparam int PRESSURE_HOLD = 800;
    localparam int REPORT_LIMIT = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_INDEX = 2'd3;

    typedef struct packed {
        logic [5:0] chunk;
        logic [LANES-1:0][COLOR_W-1:0] lanes;
        logic last;
    } ramp_chunk_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [1:0] operation = OP_CLEAR;
    logic [7:0] stop_pos = 8'd0;
    logic [31:0] stop_color = 32'd0;
    logic pop = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_REFLECT;
    logic cfg_data = 1'b0;

    logic full;
    logic empty;
    logic cfg_ready;
    logic [5:0] chunk_index;
    logic [31:0] color_0, color_1, color_2, color_3;
    logic [31:0] color_4, color_5, color_6, color_7;
    logic last;

    // predictor state
    logic [7:0] stop_pos_m [MAX_STOPS];
    color_t stop_color_m [MAX_STOPS];
    int stop_total = 0;
    logic reflect_on = 1'b0;
    logic swap_on = 1'b0;

    ramp_chunk_t pending_chunks [$];
    int mismatch_count = 0;
    int sent_count = 0;
    int send_gap_max = 12;
    int pop_gap_max = 12;
    int hold_left = 0;

    gradient_ramp_table_generator_unit #(
        .MAX_STOPS(MAX_STOPS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .operation(operation),
        .stop_pos(stop_pos),
        .stop_color(stop_color),
        .empty(empty),
        .pop(pop),
        .chunk_index(chunk_index),
        .color_0(color_0),
        .color_1(color_1),
        .color_2(color_2),
        .color_3(color_3),
        .color_4(color_4),
        .color_5(color_5),
        .color_6(color_6),
        .color_7(color_7),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("gradient_ramp_table_generator_unit regression: fail");
        $finish;
    end

    // truncating per-channel interpolation, division rounds toward zero
    function automatic logic [7:0] blend(color_t c_start, color_t c_end, int lsb, int t,
                                         int span);
        int a;
        int b;
        int v;
        a = int'(c_start[lsb +: 8]);
        b = int'(c_end[lsb +: 8]);
        v = a + ((b - a) * t) / span;
        return v[7:0];
    endfunction

    function automatic void predict_ramp();
        color_t ramp [RAMP_ENTRIES];
        ramp_chunk_t item;
        int idx;
        int k;
        int p0;
        int p1;
        int span;
        int chunks;
        int c;
        int j;
        int e;
        logic [7:0] r0, r1, r2, ra;
        if (stop_total == 0) begin
            for (idx = 0; idx < RAMP_ENTRIES; idx++)
                ramp[idx] = '0;
        end else begin
            for (idx = 0; idx <= int'(stop_pos_m[0]); idx++)
                ramp[idx] = stop_color_m[0];
            for (k = 0; k + 1 < stop_total; k++) begin
                p0 = int'(stop_pos_m[k]);
                p1 = int'(stop_pos_m[k + 1]);
                span = p1 - p0;
                if (span <= 0)
                    continue;
                for (idx = p0; idx < p1; idx++) begin
                    r0 = blend(stop_color_m[k], stop_color_m[k + 1], 0, idx - p0, span);
                    r1 = blend(stop_color_m[k], stop_color_m[k + 1], 8, idx - p0, span);
                    r2 = blend(stop_color_m[k], stop_color_m[k + 1], 16, idx - p0, span);
                    ra = blend(stop_color_m[k], stop_color_m[k + 1], 24, idx - p0, span);
                    ramp[idx] = swap_on ? {ra, r0, r1, r2} : {ra, r2, r1, r0};
                end
            end
            // tail runs on from wherever the last applied span ended
            for (; idx < RAMP_ENTRIES; idx++)
                ramp[idx] = stop_color_m[stop_total - 1];
        end
        chunks = (reflect_on ? 2 * RAMP_ENTRIES : RAMP_ENTRIES) / LANES;
        for (c = 0; c < chunks; c++) begin
            item.chunk = 6'(c);
            for (j = 0; j < LANES; j++) begin
                e = c * LANES + j;
                item.lanes[j] = (e < RAMP_ENTRIES) ? ramp[e] : ramp[2 * RAMP_ENTRIES - 1 - e];
            end
            item.last = (c == chunks - 1);
            pending_chunks.insert(pending_chunks.size(), item);
        end
    endfunction

    function automatic void apply_request(logic [1:0] op, logic [7:0] pos, color_t color);
        case (op)
            OP_CLEAR: stop_total = 0;
            OP_APPEND:
                if (stop_total < MAX_STOPS) begin
                    stop_pos_m[stop_total] = pos;
                    stop_color_m[stop_total] = color;
                    stop_total++;
                end
            OP_GENERATE: predict_ramp();
            default: ;
        endcase
    endfunction

    // push stays high on return so back-to-back requests need no extra step
    task automatic send_request(logic [1:0] op, logic [7:0] pos, color_t color);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        operation <= op;
        stop_pos <= pos;
        stop_color <= color;
        @(posedge clk);
        while (full)
            @(posedge clk);
        apply_request(op, pos, color);
        if (op != OP_UNUSED)
            sent_count++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == CFG_REFLECT)
            reflect_on = value;
        else if (index == CFG_SWAP)
            swap_on = value;
    endtask

    task automatic change_settings(logic reflect, logic swap);
        logic [CFG_INDEX_W-1:0] spare;
        spare = CFG_INDEX_W'($urandom_range(CFG_SWAP + 1, CFG_TOP_INDEX));
        wait_idle();
        write_register(CFG_REFLECT, reflect);
        write_register(spare, 1'($urandom));
        write_register(CFG_SWAP, swap);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic check_chunk();
        ramp_chunk_t want;
        logic [LANES-1:0][COLOR_W-1:0] got_lanes;
        int j;
        got_lanes = {color_7, color_6, color_5, color_4, color_3, color_2, color_1, color_0};
        if (pending_chunks.size() == 0) begin
            note_mismatch("chunk with nothing pending, index", 32'd0, 32'(chunk_index));
            return;
        end
        want = pending_chunks.pop_front();
        if (chunk_index !== want.chunk)
            note_mismatch("chunk_index", 32'(want.chunk), 32'(chunk_index));
        for (j = 0; j < LANES; j++)
            if (got_lanes[j] !== want.lanes[j])
                note_mismatch($sformatf("chunk %0d color_%0d", want.chunk, j),
                              want.lanes[j], got_lanes[j]);
        if (last !== want.last)
            note_mismatch($sformatf("chunk %0d last", want.chunk), 32'(want.last),
                          32'(last));
    endtask

    // result side: random stalls, plus a long hold when the pressure test asks
    initial
    begin : result_side
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            if (taken % 32 == 0)
                pop_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            stall = $urandom_range(0, pop_gap_max);
            if (hold_left > 0) begin
                stall += hold_left;
                hold_left = 0;
            end
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            check_chunk();
            taken++;
        end
    end

    // ignored opcode, then a ramp from an empty list under reset settings
    task automatic test_reset_state();
        send_request(OP_UNUSED, 8'($urandom), 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
    endtask

    // one stop at the top position: the leading fill covers the whole ramp
    task automatic test_single_stop();
        send_request(OP_CLEAR, 8'($urandom), 32'($urandom));
        send_request(OP_APPEND, 8'd255, 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
    endtask

    // seventeen stops with equal and falling pairs; the last one must be dropped
    task automatic test_full_list();
        logic [7:0] positions [17];
        int k;
        color_t color;
        positions = '{8'd0, 8'd0, 8'd40, 8'd30, 8'd90, 8'd90, 8'd120, 8'd200, 8'd160,
                      8'd180, 8'd181, 8'd220, 8'd250, 8'd245, 8'd255, 8'd255, 8'd7};
        send_request(OP_CLEAR, 8'($urandom), 32'($urandom));
        for (k = 0; k < 17; k++) begin
            if (k == 0)
                color = 32'hFFFF_FFFF;
            else if (k == 1 || k == 14)
                color = 32'h0000_0000;
            else
                color = 32'($urandom);
            send_request(OP_APPEND, positions[k], color);
        end
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
    endtask

    // mostly clear / appends / generate sequences, some loose requests in between
    task automatic test_random_mix(logic reflect, logic swap, int quota);
        int goal;
        int n;
        int k;
        int p;
        bit sorted;
        change_settings(reflect, swap);
        goal = sent_count + quota;
        while (sent_count < goal) begin
            send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            if ($urandom_range(0, 6) != 0) begin
                send_request(OP_CLEAR, 8'($urandom), 32'($urandom));
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
                sorted = ($urandom_range(0, 3) != 0);
                p = $urandom_range(0, 60);
                for (k = 0; k < n; k++) begin
                    if (sorted) begin
                        send_request(OP_APPEND, 8'(p), 32'($urandom));
                        p += $urandom_range(1, 80);
                        if (p > 255)
                            p = 255;
                    end else begin
                        send_request(OP_APPEND, 8'($urandom), 32'($urandom));
                    end
                end
                send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
            end else begin
                send_request(2'($urandom_range(0, OP_UNUSED)), 8'($urandom), 32'($urandom));
            end
        end
    endtask

    // results held back while generates keep coming, so the input fills up
    task automatic test_backpressure();
        int k;
        send_gap_max = 0;
        hold_left = PRESSURE_HOLD;
        send_request(OP_CLEAR, 8'($urandom), 32'($urandom));
        for (k = 0; k < 3; k++)
            send_request(OP_APPEND, 8'(k * 100), 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
        send_request(OP_APPEND, 8'($urandom), 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
        send_request(OP_GENERATE, 8'($urandom), 32'($urandom));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_single_stop();
        test_full_list();
        test_random_mix(1'b1, 1'b0, 110);
        test_random_mix(1'b0, 1'b1, 110);
        test_random_mix(1'b1, 1'b1, 110);
        test_random_mix(1'b0, 1'b0, 110);
        test_backpressure();
        wait_idle();
        if (mismatch_count == 0 && pending_chunks.size() == 0)
            $display("gradient_ramp_table_generator_unit regression: pass");
        else
            $display("gradient_ramp_table_generator_unit regression: fail");
        $finish;
    end

endmodule

>>> gradient_ramp_table_generator_unit.f
design/grtg_pkg.sv
design/grtg_front.sv
design/grtg_queue.sv
design/grtg_div.sv
design/grtg_back.sv
design/gradient_ramp_table_generator_unit.sv
verif/tb_top.sv
